FILE: src/kfr_pkg.sv
// Shared types and constants for the KISS frame receiver.
`timescale 1ns / 1ps
package kfr_pkg;

    localparam logic [7:0] KS_FEND  = 8'hC0;
    localparam logic [7:0] KS_FESC  = 8'hDB;
    localparam logic [7:0] KS_TFEND = 8'hDC;
    localparam logic [7:0] KS_TFESC = 8'hDD;

    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;
    localparam logic [1:0] EV_PARAM   = 2'd3;

    localparam logic [3:0] CMD_FRAME   = 4'd0;
    localparam logic [3:0] CMD_KEYUP   = 4'd1;
    localparam logic [3:0] CMD_PERSIST = 4'd2;
    localparam logic [3:0] CMD_SLOT    = 4'd3;
    localparam logic [3:0] CMD_TAIL    = 4'd4;
    localparam logic [3:0] CMD_DUPLEX  = 4'd5;
    localparam logic [3:0] CMD_SETHW   = 4'd6;
    localparam logic [3:0] CMD_GETHW   = 4'd7;

    localparam logic [7:0] TXDELAY_RST  = 8'd50;
    localparam logic [7:0] PERSIST_RST  = 8'd63;
    localparam logic [7:0] SLOTTIME_RST = 8'd10;
    localparam logic [7:0] TXTAIL_RST   = 8'd10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int POS_W = 10;

    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] unesc;
        logic       is_fend;
        logic       is_fesc;
    } kfr_word_t;

endpackage

FILE: src/kfr_if.sv
// Handshake channels for the KISS frame receiver: input byte and result word.
`timescale 1ns / 1ps

interface kfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic [9:0] position;
    logic [3:0] command_code;
    logic [3:0] port_number;
    logic [7:0] tx_delay_now;
    logic [7:0] persistence_now;
    logic [7:0] slot_time_now;
    logic [7:0] tx_tail_now;
    logic       full_duplex_now;

    modport source (
        output valid, input ready,
        output event_res, output data_byte, output position,
        output command_code, output port_number,
        output tx_delay_now, output persistence_now, output slot_time_now,
        output tx_tail_now, output full_duplex_now
    );
    modport sink (
        input valid, output ready,
        input event_res, input data_byte, input position,
        input command_code, input port_number,
        input tx_delay_now, input persistence_now, input slot_time_now,
        input tx_tail_now, input full_duplex_now
    );
endinterface

FILE: src/kfr_front.sv
// Front end: accepts raw bytes and classifies them for the word queue.
`timescale 1ns / 1ps
module kfr_front
    import kfr_pkg::*;
(
    kfr_in_if.sink     rx,
    output logic       push_valid,
    input  logic       push_ready,
    output kfr_word_t  push_word
);

    always_comb
    begin
        push_word.raw     = rx.rx_byte;
        push_word.is_fend = (rx.rx_byte == KS_FEND);
        push_word.is_fesc = (rx.rx_byte == KS_FESC);
        case (rx.rx_byte)
            KS_TFEND: push_word.unesc = KS_FEND;
            KS_TFESC: push_word.unesc = KS_FESC;
            default:  push_word.unesc = rx.rx_byte;
        endcase
    end

    assign push_valid = rx.valid;
    assign rx.ready   = push_ready;

endmodule

FILE: src/kfr_queue.sv
// Short queue of classified words between front and back ends.
`timescale 1ns / 1ps
module kfr_queue
    import kfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  kfr_word_t push_word,
    output logic      pop_valid,
    input  logic      pop_ready,
    output kfr_word_t pop_word
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kfr_word_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: src/kfr_back.sv
// Back end: frame state, counting, parameter commands and the result register.
`timescale 1ns / 1ps
module kfr_back
    import kfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  kfr_word_t pop_word,
    kfr_out_if.source res
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic             open_reg,  open_next;
    logic             esc_reg,   esc_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       txd_reg,   txd_next;
    logic [7:0]       pers_reg,  pers_next;
    logic [7:0]       slot_reg,  slot_next;
    logic [7:0]       tail_reg,  tail_next;
    logic             dup_reg,   dup_next;

    logic             out_valid_reg;
    logic [1:0]       ev_reg,    ev_next;
    logic [7:0]       data_reg,  data_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [3:0]       code_reg;
    logic [3:0]       port_reg;
    logic [7:0]       txd_o_reg, pers_o_reg, slot_o_reg, tail_o_reg;
    logic             dup_o_reg;

    logic             has_res;
    logic             take;
    logic [7:0]       b;
    logic [3:0]       cmd;
    logic [CNT_W+POS_W-1:0] cnt_ext;

    assign pop_ready = !out_valid_reg || res.ready;
    assign take      = pop_valid && pop_ready;
    assign cnt_ext   = {{POS_W{1'b0}}, cnt_reg};
    assign cmd       = first_reg[3:0];

    always_comb
    begin
        open_next  = open_reg;
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        txd_next   = txd_reg;
        pers_next  = pers_reg;
        slot_next  = slot_reg;
        tail_next  = tail_reg;
        dup_next   = dup_reg;
        has_res    = 1'b0;
        ev_next    = EV_BYTE;
        data_next  = '0;
        pos_next   = '0;
        b          = esc_reg ? pop_word.unesc : pop_word.raw;

        if (pop_word.is_fend)
        begin
            if (open_reg && cnt_reg != '0)
            begin
                open_next = 1'b0;
                has_res   = 1'b1;
                ev_next   = EV_DONE;
                pos_next  = cnt_ext[POS_W-1:0];
            end
            else
            begin
                cnt_next  = '0;
                esc_next  = 1'b0;
                open_next = 1'b1;
            end
        end
        else if (open_reg && !esc_reg && pop_word.is_fesc)
        begin
            esc_next = 1'b1;
        end
        else if (open_reg)
        begin
            esc_next = 1'b0;
            has_res  = 1'b1;
            if (cnt_reg >= CNT_W'(MAX_FRAME_BYTES))
            begin
                cnt_next  = '0;
                open_next = 1'b0;
                ev_next   = EV_DISCARD;
            end
            else if (cnt_reg == '0)
            begin
                first_next = b;
                cnt_next   = CNT_W'(1);
                data_next  = b;
            end
            else if (cnt_reg == CNT_W'(1) && cmd != CMD_FRAME && cmd != CMD_SETHW
                     && cmd != CMD_GETHW)
            begin
                case (cmd)
                    CMD_KEYUP:   txd_next  = b;
                    CMD_PERSIST: pers_next = b;
                    CMD_SLOT:    slot_next = b;
                    CMD_TAIL:    tail_next = b;
                    CMD_DUPLEX:  dup_next  = (b != 8'd0);
                    default:     ;
                endcase
                cnt_next  = '0;
                open_next = 1'b0;
                ev_next   = EV_PARAM;
                data_next = b;
                pos_next  = POS_W'(1);
            end
            else
            begin
                cnt_next  = cnt_reg + CNT_W'(1);
                data_next = b;
                pos_next  = cnt_ext[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            esc_reg       <= 1'b0;
            cnt_reg       <= '0;
            first_reg     <= '0;
            txd_reg       <= TXDELAY_RST;
            pers_reg      <= PERSIST_RST;
            slot_reg      <= SLOTTIME_RST;
            tail_reg      <= TXTAIL_RST;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                open_reg  <= open_next;
                esc_reg   <= esc_next;
                cnt_reg   <= cnt_next;
                first_reg <= first_next;
                txd_reg   <= txd_next;
                pers_reg  <= pers_next;
                slot_reg  <= slot_next;
                tail_reg  <= tail_next;
                dup_reg   <= dup_next;
                out_valid_reg <= has_res;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_res)
        begin
            ev_reg     <= ev_next;
            data_reg   <= data_next;
            pos_reg    <= pos_next;
            code_reg   <= first_next[3:0];
            port_reg   <= first_next[7:4];
            txd_o_reg  <= txd_next;
            pers_o_reg <= pers_next;
            slot_o_reg <= slot_next;
            tail_o_reg <= tail_next;
            dup_o_reg  <= dup_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.event_res       = ev_reg;
    assign res.data_byte       = data_reg;
    assign res.position        = pos_reg;
    assign res.command_code    = code_reg;
    assign res.port_number     = port_reg;
    assign res.tx_delay_now    = txd_o_reg;
    assign res.persistence_now = pers_o_reg;
    assign res.slot_time_now   = slot_o_reg;
    assign res.tx_tail_now     = tail_o_reg;
    assign res.full_duplex_now = dup_o_reg;

endmodule

FILE: src/kiss_frame_receiver_unit.sv
// KISS frame receiver: top level joining front end, word queue and back end.
//
// Usage: raw serial bytes enter on rx (valid/ready, field rx_byte), one per word.
// FEND/FESC framing is removed; each stored byte leaves on res with its
// position, a closing FEND reports the frame length, an over-long frame is
// reported as discarded, and a two-byte command frame updates a TNC setting.
// Every result word carries the current settings and the first byte's nibbles.
// Throughput: one byte per cycle sustained while res.ready is high; the back end
// updates its frame state once per word.
// An accepted byte is written into the two-word queue, the back end takes it
// from there and registers its result, which is presented until taken.
// Bytes that cause no result (FEND opening a frame, FESC, bytes outside a
// frame) still pass through the queue and are taken by the back end.
// Stall: if res.ready is low the result register holds, the queue fills and
// rx.ready drops once the queue holds two words.
// Reset: rst_n clears the frame state, the queue and the result register and
// restores the default settings (TX delay 50, persistence 63, slot time 10,
// TX tail 10, half duplex).
`timescale 1ns / 1ps
module kiss_frame_receiver_unit
    import kfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    kfr_in_if.sink    rx,
    kfr_out_if.source res
);

    logic      push_valid;
    logic      push_ready;
    kfr_word_t push_word;
    logic      pop_valid;
    logic      pop_ready;
    kfr_word_t pop_word;

    kfr_front u_front (
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    kfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    kfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .res       (res)
    );

endmodule

FILE: tb/tb.sv
// Self-checking bench for kiss_frame_receiver_unit: random KISS byte streams, result words checked.
`timescale 1ns / 1ps
module tb;
    import kfr_pkg::*;

    localparam int FRAME_MAX   = 512;
    localparam int HOLD_LEN    = 200;
    localparam int SETTLE      = 10;
    localparam int PHASE_ITEMS = 90;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic [9:0] position;
        logic [3:0] command_code;
        logic [3:0] port_number;
        logic [7:0] tx_delay;
        logic [7:0] persistence;
        logic [7:0] slot_time;
        logic [7:0] tx_tail;
        logic       full_duplex;
    } kiss_word_t;

    logic clk;
    logic rst_n;

    kfr_in_if  rx();
    kfr_out_if res();

    kiss_frame_receiver_unit #(.MAX_FRAME_BYTES(FRAME_MAX)) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx),
        .res  (res)
    );

    // predicted deframer state
    logic        frame_live;
    logic        esc_armed;
    int unsigned stored_cnt;
    logic [7:0]  lead_byte;
    logic [7:0]  txd_set;
    logic [7:0]  pers_set;
    logic [7:0]  slot_set;
    logic [7:0]  tail_set;
    logic        dup_set;

    logic [7:0] feed_q[$];
    kiss_word_t due_words[$];

    logic in_taken;
    int   mismatches;
    int   queued_cnt;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_asks;
    int   hold_served;
    int   hold_left;
    int   cycle_cnt;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic       takes;
        logic       emit;
        kiss_word_t w;
        b     = raw;
        takes = 1'b0;
        emit  = 1'b0;
        w     = '0;
        if (b == KS_FEND)
        begin
            if (frame_live && stored_cnt > 0)
            begin
                frame_live = 1'b0;
                w.event_res = EV_DONE;
                w.position  = stored_cnt[9:0];
                emit = 1'b1;
            end
            else
            begin
                stored_cnt = 0;
                esc_armed  = 1'b0;
                frame_live = 1'b1;
            end
        end
        else if (frame_live)
        begin
            if (esc_armed)
            begin
                esc_armed = 1'b0;
                if (b == KS_TFEND)
                    b = KS_FEND;
                else if (b == KS_TFESC)
                    b = KS_FESC;
                takes = 1'b1;
            end
            else if (b == KS_FESC)
                esc_armed = 1'b1;
            else
                takes = 1'b1;
        end

        if (takes)
        begin
            emit = 1'b1;
            if (stored_cnt >= FRAME_MAX)
            begin
                stored_cnt  = 0;
                esc_armed   = 1'b0;
                frame_live  = 1'b0;
                w.event_res = EV_DISCARD;
            end
            else if (stored_cnt == 0)
            begin
                lead_byte   = b;
                stored_cnt  = 1;
                w.event_res = EV_BYTE;
                w.data_byte = b;
            end
            else if (stored_cnt == 1 && lead_byte[3:0] != CMD_FRAME
                     && lead_byte[3:0] != CMD_SETHW && lead_byte[3:0] != CMD_GETHW)
            begin
                case (lead_byte[3:0])
                    CMD_KEYUP:   txd_set  = b;
                    CMD_PERSIST: pers_set = b;
                    CMD_SLOT:    slot_set = b;
                    CMD_TAIL:    tail_set = b;
                    CMD_DUPLEX:  dup_set  = (b != 8'h00);
                    default: ;
                endcase
                stored_cnt  = 0;
                esc_armed   = 1'b0;
                frame_live  = 1'b0;
                w.event_res = EV_PARAM;
                w.data_byte = b;
                w.position  = 10'd1;
            end
            else
            begin
                w.event_res = EV_BYTE;
                w.data_byte = b;
                w.position  = stored_cnt[9:0];
                stored_cnt  = stored_cnt + 1;
            end
        end

        if (emit)
        begin
            w.command_code = lead_byte[3:0];
            w.port_number  = lead_byte[7:4];
            w.tx_delay     = txd_set;
            w.persistence  = pers_set;
            w.slot_time    = slot_set;
            w.tx_tail      = tail_set;
            w.full_duplex  = dup_set;
            due_words.push_back(w);
        end
    endtask

    function automatic string word_text(input kiss_word_t w);
        return $sformatf({"ev=%0d data=%h pos=%0d cmd=%h port=%h ",
                          "txd=%0d pers=%0d slot=%0d tail=%0d dup=%0d"},
                         w.event_res, w.data_byte, w.position, w.command_code, w.port_number,
                         w.tx_delay, w.persistence, w.slot_time, w.tx_tail, w.full_duplex);
    endfunction

    // monitor: result words checked first, then the accepted input byte is predicted
    always @(posedge clk)
    begin : monitor
        kiss_word_t seen;
        kiss_word_t want;
        if (!rst_n)
        begin
            frame_live = 1'b0;
            esc_armed  = 1'b0;
            stored_cnt = 0;
            lead_byte  = 8'h00;
            txd_set    = TXDELAY_RST;
            pers_set   = PERSIST_RST;
            slot_set   = SLOTTIME_RST;
            tail_set   = TXTAIL_RST;
            dup_set    = 1'b0;
            in_taken   = 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                seen = {res.event_res, res.data_byte, res.position, res.command_code,
                        res.port_number, res.tx_delay_now, res.persistence_now,
                        res.slot_time_now, res.tx_tail_now, res.full_duplex_now};
                if (due_words.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word: %s", $realtime, word_text(seen));
                end
                else
                begin
                    want = due_words.pop_front();
                    if (seen !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, word_text(want), word_text(seen));
                    end
                end
            end
            in_taken = rx.valid && rx.ready;
            if (in_taken)
                deframe_byte(rx.rx_byte);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rx.valid <= 1'b0;
        else if (!rx.valid || in_taken)
        begin
            if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rx.valid   <= 1'b1;
                rx.rx_byte <= feed_q.pop_front();
            end
            else
                rx.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_served != hold_asks)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_raw(input logic [7:0] b);
        feed_q.push_back(b);
        queued_cnt = queued_cnt + 1;
    endtask

    // occasional stray FESC before a plain byte: taken literally
    task automatic push_stuffed(input logic [7:0] b);
        if (b == KS_FEND)
        begin
            push_raw(KS_FESC);
            push_raw(KS_TFEND);
        end
        else if (b == KS_FESC)
        begin
            push_raw(KS_FESC);
            push_raw(KS_TFESC);
        end
        else
        begin
            if ($urandom_range(29) == 0 && b != KS_TFEND && b != KS_TFESC)
                push_raw(KS_FESC);
            push_raw(b);
        end
    endtask

    function automatic logic [7:0] pick_content();
        case ($urandom_range(11))
            0:       return KS_FEND;
            1:       return KS_FESC;
            2:       return KS_TFEND;
            3:       return KS_TFESC;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame();
        int         kind;
        int         len;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            case ($urandom_range(2))
                0:       lead = {4'($urandom), CMD_FRAME};
                1:       lead = {4'($urandom), CMD_SETHW};
                default: lead = {4'($urandom), CMD_GETHW};
            endcase
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
            push_raw(KS_FEND);
            push_stuffed(lead);
            repeat (len) push_stuffed(pick_content());
            push_raw(KS_FEND);
        end
        else if (kind < 80)
        begin
            if ($urandom_range(3) == 0)
                lead = 8'($urandom);
            else
                lead = {4'($urandom), 4'($urandom_range(CMD_KEYUP, CMD_DUPLEX))};
            push_raw(KS_FEND);
            push_stuffed(lead);
            push_stuffed(pick_content());
            push_raw(KS_FEND);
        end
        else if (kind < 88)
            repeat ($urandom_range(1, 8)) push_raw(8'($urandom));
        else if (kind < 95)
        begin
            push_raw(KS_FEND);
            push_stuffed(8'($urandom));
            repeat ($urandom_range(0, 4)) push_stuffed(pick_content());
            case ($urandom_range(2))
                0:
                begin
                    push_raw(KS_FESC);
                    push_raw(KS_FEND);
                end
                1: ;
                default:
                begin
                    push_raw(KS_FEND);
                    push_raw(KS_FEND);
                end
            endcase
        end
        else
        begin
            push_raw(KS_FEND);
            push_raw(KS_FEND);
        end
    endtask

    task automatic queue_long(input int n, input bit esc_tail);
        push_raw(KS_FEND);
        push_stuffed({4'($urandom), CMD_FRAME});
        repeat (n - 1) push_stuffed(8'($urandom));
        if (esc_tail)
        begin
            push_raw(KS_FESC);
            push_raw(KS_TFEND);
        end
        push_raw(KS_FEND);
    endtask

    task automatic queue_random(input int n);
        int start;
        start = queued_cnt;
        while (queued_cnt - start < n)
            queue_frame();
    endtask

    task automatic wait_fed();
        while (feed_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic drain();
        wait_fed();
        while (rx.valid || due_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] opening[$];
        opening = {KS_FEND, 8'h50, KS_FESC, KS_TFEND, KS_FESC, KS_TFESC, KS_FESC, 8'h41,
                   KS_FESC, KS_FESC, 8'hFF, KS_FEND,
                   8'h55, KS_FEND, KS_FEND, 8'h01, 8'hFF, KS_FEND,
                   8'h45, 8'h02, KS_FEND,
                   8'hFF, 8'h11, KS_FEND,
                   8'h00, KS_FESC, KS_FEND};
        rx.valid       = 1'b0;
        rx.rx_byte     = 8'h00;
        res.ready      = 1'b0;
        rst_n          = 1'b0;
        mismatches     = 0;
        queued_cnt     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks      = 0;
        hold_served    = 0;
        hold_left      = 0;
        cycle_cnt      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening[i]) push_raw(opening[i]);
        queue_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 45;
        queue_random(PHASE_ITEMS);
        wait_fed();

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        queue_random(PHASE_ITEMS);
        wait_fed();

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_random(PHASE_ITEMS);
        queue_long(FRAME_MAX, 1'b0);
        queue_long(FRAME_MAX, 1'b1);
        queue_random(40);
        drain();

        // long receiver hold-off with the sender flat out
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks      = hold_asks + 1;
        queue_long(40, 1'b0);
        queue_random(40);
        drain();

        if (mismatches == 0 && due_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/kfr_pkg.sv
src/kfr_if.sv
src/kfr_front.sv
src/kfr_queue.sv
src/kfr_back.sv
src/kiss_frame_receiver_unit.sv
tb/tb.sv
